// File: sv/qebr_pkg.sv
package qebr_pkg;

   localparam int unsigned REG_W = 8;
   localparam int unsigned CSR_INDEX_W = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_PERIOD_LO      = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PERIOD_HI      = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TICKS_PER_STEP = 2'd2;

   localparam logic [REG_W-1:0] PERIOD_LO_RESET      = 8'd2;
   localparam logic [REG_W-1:0] PERIOD_HI_RESET      = 8'd255;
   localparam logic [REG_W-1:0] TICKS_PER_STEP_RESET = 8'd5;
   localparam logic [REG_W-1:0] PERIOD_RESET         = 8'd127;

   typedef struct packed {
      logic                    led_on;
      logic                    led_toggled;
      logic [REG_W-1:0]        period_steps;
      logic signed [REG_W-1:0] raw_delta;
   } result_type;

   typedef struct packed {
      logic enc_a;
      logic enc_b;
   } tick_type;

endpackage

// File: sv/quadrature_encoder_blink_rate.sv
// Quadrature encoder to LED blink rate controller.
//
// Request channel (req_valid / req_stall): one transfer per 1 ms tick,
// carrying the two encoder pin levels req_enc_a and req_enc_b.
// Response channel (rsp_valid / rsp_stall): exactly one transfer per tick,
// in order, with the LED level, a toggle flag, the clamped blink period
// and the accumulated encoder delta after that tick.
// Config port (csr_we / csr_index / csr_data): index 0 lowest period,
// 1 highest period, 2 ticks_per_step; index 3 is ignored. Write while idle.
//
// A request is captured in the input register, then the update logic
// feeds the response register, and the response is valid once that
// register is loaded; while rsp_stall holds it, the tick waits in the input register.
// One tick is taken per cycle while the receiver does not stall; the state update is a single
// add-and-clamp between those two registers.
// Reset clears both valid flags and returns all state and config to
// defaults. While the receiver stalls, the response holds and the input
// register fills, after which req_stall is raised until rsp_stall drops.
module quadrature_encoder_blink_rate (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_enc_a,
   input  logic                                req_enc_b,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_led_on,
   output logic                                rsp_led_toggled,
   output logic [qebr_pkg::REG_W-1:0]          rsp_period_steps,
   output logic signed [qebr_pkg::REG_W-1:0]   rsp_raw_delta,
   input  logic                                csr_we,
   input  logic [qebr_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [qebr_pkg::REG_W-1:0]          csr_data
);

   qebr_pkg::tick_type   req_tick;
   qebr_pkg::tick_type   tick;
   qebr_pkg::result_type result;
   qebr_pkg::result_type rsp_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 tick_valid;
   logic                 advance;

   assign req_tick.enc_a = req_enc_a;
   assign req_tick.enc_b = req_enc_b;
   assign advance        = tick_valid && (!rsp_valid_ff || !rsp_stall);

   qebr_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_tick   (req_tick),
      .advance    (advance),
      .tick_valid (tick_valid),
      .tick       (tick)
   );

   qebr_core u_core (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .advance   (advance),
      .tick      (tick),
      .result    (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_led_on       = rsp_ff.led_on;
   assign rsp_led_toggled  = rsp_ff.led_toggled;
   assign rsp_period_steps = rsp_ff.period_steps;
   assign rsp_raw_delta    = rsp_ff.raw_delta;

endmodule

// File: sv/qebr_in_reg.sv
module qebr_in_reg (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  qebr_pkg::tick_type req_tick,
   input  logic               advance,
   output logic               tick_valid,
   output qebr_pkg::tick_type tick
);

   logic               valid_ff;
   logic               valid_in;
   qebr_pkg::tick_type tick_ff;
   logic               load;

   assign req_stall  = valid_ff && !advance;
   assign load       = req_valid && !req_stall;
   assign tick_valid = valid_ff;
   assign tick       = tick_ff;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         tick_ff <= req_tick;
      end
   end

endmodule

// File: sv/qebr_core.sv
module qebr_core (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      csr_we,
   input  logic [qebr_pkg::CSR_INDEX_W-1:0]          csr_index,
   input  logic [qebr_pkg::REG_W-1:0]                csr_data,
   input  logic                                      advance,
   input  qebr_pkg::tick_type                        tick,
   output qebr_pkg::result_type                      result
);

   logic [qebr_pkg::REG_W-1:0] period_lo_ff;
   logic [qebr_pkg::REG_W-1:0] period_hi_ff;
   logic [qebr_pkg::REG_W-1:0] ticks_per_step_ff;

   logic [1:0]                 last_code_ff, last_code_in;
   logic [qebr_pkg::REG_W-1:0] delta_ff, delta_in;
   logic [qebr_pkg::REG_W-1:0] period_ff, period_in;
   logic [qebr_pkg::REG_W-1:0] countdown_ff, countdown_in;
   logic [qebr_pkg::REG_W-1:0] phase_ff, phase_in;
   logic                       led_ff, led_in;

   logic [1:0]                 code;
   logic [1:0]                 diff;
   logic [qebr_pkg::REG_W-1:0] delta_enc;
   logic [qebr_pkg::REG_W-1:0] phase_inc;
   logic                       step;
   logic signed [qebr_pkg::REG_W-1:0] shifted;
   logic signed [qebr_pkg::REG_W+1:0] sum;
   logic                       toggled;

   always_ff @(posedge clock) begin
      if (reset) begin
         period_lo_ff      <= qebr_pkg::PERIOD_LO_RESET;
         period_hi_ff      <= qebr_pkg::PERIOD_HI_RESET;
         ticks_per_step_ff <= qebr_pkg::TICKS_PER_STEP_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            qebr_pkg::CSR_PERIOD_LO:      period_lo_ff      <= csr_data;
            qebr_pkg::CSR_PERIOD_HI:      period_hi_ff      <= csr_data;
            qebr_pkg::CSR_TICKS_PER_STEP: ticks_per_step_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      code      = {tick.enc_a, tick.enc_a ^ tick.enc_b};
      diff      = last_code_ff - code;
      last_code_in = last_code_ff;
      delta_enc = delta_ff;
      if (diff[0]) begin
         last_code_in = code;
         delta_enc    = diff[1] ? delta_ff + 8'd1 : delta_ff - 8'd1;
      end

      phase_inc = phase_ff + 8'd1;
      step      = (phase_inc >= ticks_per_step_ff);
      shifted   = $signed(delta_enc) >>> 1;
      sum       = $signed({2'b00, period_ff}) + {{2{shifted[qebr_pkg::REG_W-1]}}, shifted};

      phase_in     = phase_inc;
      delta_in     = delta_enc;
      period_in    = period_ff;
      countdown_in = countdown_ff;
      led_in       = led_ff;
      toggled      = 1'b0;

      if (step) begin
         phase_in = '0;
         delta_in = {{(qebr_pkg::REG_W-1){1'b0}}, delta_enc[0]};
         priority if (sum > $signed({2'b00, period_hi_ff})) begin
            period_in = period_hi_ff;
         end else if (sum < $signed({2'b00, period_lo_ff})) begin
            period_in = period_lo_ff;
         end else begin
            period_in = sum[qebr_pkg::REG_W-1:0];
         end
         if (countdown_ff <= 8'd1) begin
            led_in       = !led_ff;
            countdown_in = period_in;
            toggled      = 1'b1;
         end else begin
            countdown_in = countdown_ff - 8'd1;
         end
      end

      result.led_on       = led_in;
      result.led_toggled  = toggled;
      result.period_steps = period_in;
      result.raw_delta    = $signed(delta_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_code_ff <= '0;
         delta_ff     <= '0;
         period_ff    <= qebr_pkg::PERIOD_RESET;
         countdown_ff <= qebr_pkg::PERIOD_RESET;
         phase_ff     <= '0;
         led_ff       <= 1'b0;
      end else if (advance) begin
         last_code_ff <= last_code_in;
         delta_ff     <= delta_in;
         period_ff    <= period_in;
         countdown_ff <= countdown_in;
         phase_ff     <= phase_in;
         led_ff       <= led_in;
      end
   end

endmodule
